// ===== hw/rtl/rhc_pkg.sv =====
// shared types, widths and constants for the rgb to hsl converter
package rhc_pkg;

  // field widths
  localparam int CH_W     = 8;   // one color channel
  localparam int FIELD_W  = 15;  // hue, saturation, lightness fields
  localparam int SUM_W    = 9;   // max + min
  localparam int HNUM_W   = 11;  // hue sector numerator, below 6 * 255
  localparam int DIV_DEN_W = 8;  // both divisors fit a channel byte
  localparam int DIV_NUM_W = DIV_DEN_W + FIELD_W;

  // scale constants
  localparam int HUE_SECTOR_SCALE = 3840;   // 60 degrees times 64
  localparam int HUE_FULL_TURN    = 23040;  // 360 degrees times 64
  localparam int PCT_SCALE        = 25600;  // 100 percent times 256
  localparam int DOUBLE_FULL      = 510;
  localparam int HALF_SUM         = 255;

  // lightness = s * 2560 / 51 = 50 s + floor(10 s / 51)
  localparam int LIGHT_SLOPE    = 50;
  localparam int LIGHT_FRAC_MUL = 10;
  localparam int LIGHT_DIVISOR  = 51;
  localparam int LIGHT_RECIP    = 1285;  // floor(2^16 / 51)
  localparam int LIGHT_SHIFT    = 16;
  localparam int LIGHT_TEN_W    = 13;    // 10 * 510 fits
  localparam int LIGHT_PROD_W   = 23;
  localparam int LIGHT_Q_W      = 7;

  // quotient bits resolved per divider pipeline stage
  localparam int DIV_STEPS_PER_STAGE = 2;

  // input item
  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_t;

  // result item
  typedef struct packed {
    logic [FIELD_W-1:0] hue_out;
    logic [FIELD_W-1:0] saturation_out;
    logic [FIELD_W-1:0] lightness_out;
    logic               achromatic;
  } out_t;

endpackage

// ===== hw/rtl/rhc_div.sv =====
// pipelined restoring divider, a few quotient bits per stage
module rhc_div #(
  parameter int DEN_W = rhc_pkg::DIV_DEN_W,
  parameter int QUO_W = rhc_pkg::FIELD_W,
  parameter int STEPS = rhc_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                   clk,
  input  logic [DEN_W+QUO_W-1:0] num_i,  // quotient must fit QUO_W bits
  input  logic [DEN_W-1:0]       den_i,  // nonzero
  output logic [QUO_W-1:0]       quo_o
);

  localparam int STAGES = (QUO_W + STEPS - 1) / STEPS;

  logic [DEN_W-1:0] rem_r [STAGES];
  logic [QUO_W-1:0] lo_r  [STAGES];
  logic [QUO_W-1:0] quo_r [STAGES];
  logic [DEN_W-1:0] den_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] lo_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_nxt;
    logic [QUO_W-1:0] lo_nxt;
    logic [QUO_W-1:0] quo_nxt;

    // stage inputs: ports for the first stage, previous stage otherwise
    if (i == 0) begin : g_first
      assign rem_in = num_i[DEN_W+QUO_W-1:QUO_W];
      assign lo_in  = num_i[QUO_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign lo_in  = lo_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
    end

    // shift in one numerator bit per step, subtract when it fits
    always_comb begin
      logic [DEN_W:0] trial;
      rem_nxt = rem_in;
      lo_nxt  = lo_in;
      quo_nxt = quo_in;
      trial   = '0;
      for (int j = 0; j < STEPS; j++) begin
        if (i * STEPS + j < QUO_W) begin
          trial = {rem_nxt, lo_nxt[QUO_W-1]};
          lo_nxt = {lo_nxt[QUO_W-2:0], 1'b0};
          if (trial >= {1'b0, den_in}) begin
            rem_nxt = DEN_W'(trial - {1'b0, den_in});
            quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
          end else begin
            rem_nxt = trial[DEN_W-1:0];
            quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    // stage registers
    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      lo_r[i]  <= lo_nxt;
      quo_r[i] <= quo_nxt;
      den_r[i] <= den_in;
    end
  end

  assign quo_o = quo_r[STAGES-1];

endmodule

// ===== hw/rtl/rgb_to_hsl_convert_unit.sv =====
// rgb to hsl converter top level: pixel in, hue/saturation/lightness out
//
//  channel | ports                    | handshake
//  --------+--------------------------+-------------------------------------
//  input   | start, busy, in_data     | transfer when start && !busy
//  result  | out_strobe, out_data     | one-cycle strobe, no back pressure
//
// one pixel enters every cycle; busy is held low
// results pass through stage 1, stage 2, the divider pipeline that resolves
// hue and saturation quotients, and the output register
// synchronous active-low reset clears all valid bits; data regs are not reset
// the receiver cannot stall, so the pipeline advances every cycle
module rgb_to_hsl_convert_unit #(
  parameter int STEPS_PER_STAGE = rhc_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  rhc_pkg::in_t in_data,
  output logic         out_strobe,
  output rhc_pkg::out_t out_data
);

  localparam int DIV_STAGES = (rhc_pkg::FIELD_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int LATENCY    = DIV_STAGES + 3;

  localparam int CW = rhc_pkg::CH_W;
  localparam int SW = rhc_pkg::SUM_W;
  localparam int HW = rhc_pkg::HNUM_W;
  localparam int DW = rhc_pkg::DIV_DEN_W;
  localparam int NW = rhc_pkg::DIV_NUM_W;
  localparam int FW = rhc_pkg::FIELD_W;
  localparam int TW = rhc_pkg::LIGHT_TEN_W;
  localparam int PW = rhc_pkg::LIGHT_PROD_W;
  localparam int QW = rhc_pkg::LIGHT_Q_W;

  // lightness and grey flag riding beside the divider
  typedef struct packed {
    logic          grey;
    logic [FW-1:0] light;
  } side_t;

  logic accept;

  // stage 1 registers
  logic          s1_v_r;
  logic [CW-1:0] s1_d_r;
  logic [SW-1:0] s1_s_r;
  logic [HW-1:0] s1_hnum_r;
  logic          s1_grey_r;
  logic [CW-1:0] mx_nxt;
  logic [CW-1:0] mn_nxt;
  logic [CW-1:0] d_nxt;
  logic [HW-1:0] hnum_nxt;

  // stage 2 registers
  logic          s2_v_r;
  logic [NW-1:0] s2_sat_num_r;
  logic [NW-1:0] s2_hue_num_r;
  logic [DW-1:0] s2_sat_den_r;
  logic [DW-1:0] s2_hue_den_r;
  logic [SW-1:0] s2_s_r;
  logic [QW-1:0] s2_lq_r;
  logic          s2_grey_r;
  logic [SW-1:0] half_gap;
  logic [TW-1:0] ten_s1;
  logic [PW-1:0] lprod;

  // divider-aligned side line
  logic          dv_r [DIV_STAGES];
  side_t         sb_r [DIV_STAGES];
  side_t         sb0_nxt;
  logic [TW-1:0] ten_s2;
  logic [TW-1:0] lrem;
  logic [QW-1:0] lq_fix;

  logic [FW-1:0] sat_quo;
  logic [FW-1:0] hue_quo;

  // output registers
  logic          out_strobe_r;
  rhc_pkg::out_t out_data_r;
  logic [FW-1:0] hue_wrap;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: extremes, spread, sum and hue sector numerator
  always_comb begin
    logic [CW-1:0] r;
    logic [CW-1:0] g;
    logic [CW-1:0] b;
    r = in_data.red_in;
    g = in_data.green_in;
    b = in_data.blue_in;
    mx_nxt = (r > g) ? r : g;
    mx_nxt = (mx_nxt > b) ? mx_nxt : b;
    mn_nxt = (r < g) ? r : g;
    mn_nxt = (mn_nxt < b) ? mn_nxt : b;
    d_nxt  = mx_nxt - mn_nxt;
    if (mx_nxt == r) begin
      if (g < b) begin
        hnum_nxt = HW'(d_nxt) * HW'(6) + HW'(g) - HW'(b);
      end else begin
        hnum_nxt = HW'(g) - HW'(b);
      end
    end else if (mx_nxt == g) begin
      hnum_nxt = HW'(b) + HW'(d_nxt) * HW'(2) - HW'(r);
    end else begin
      hnum_nxt = HW'(r) + HW'(d_nxt) * HW'(4) - HW'(g);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
    s1_d_r    <= d_nxt;
    s1_s_r    <= SW'(mx_nxt) + SW'(mn_nxt);
    s1_hnum_r <= hnum_nxt;
    s1_grey_r <= (d_nxt == '0);
  end

  // stage 2: scaled numerators, divisors and lightness reciprocal estimate
  assign half_gap = SW'(rhc_pkg::DOUBLE_FULL) - s1_s_r;
  assign ten_s1   = TW'(s1_s_r) * TW'(rhc_pkg::LIGHT_FRAC_MUL);
  assign lprod    = PW'(ten_s1) * PW'(rhc_pkg::LIGHT_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_sat_num_r <= NW'(s1_d_r) * NW'(rhc_pkg::PCT_SCALE);
    s2_hue_num_r <= NW'(s1_hnum_r) * NW'(rhc_pkg::HUE_SECTOR_SCALE);
    if (s1_grey_r) begin
      s2_sat_den_r <= DW'(1);
      s2_hue_den_r <= DW'(1);
    end else begin
      s2_sat_den_r <= (s1_s_r > SW'(rhc_pkg::HALF_SUM)) ? half_gap[DW-1:0]
                                                        : s1_s_r[DW-1:0];
      s2_hue_den_r <= s1_d_r;
    end
    s2_s_r    <= s1_s_r;
    s2_lq_r   <= lprod[rhc_pkg::LIGHT_SHIFT +: QW];
    s2_grey_r <= s1_grey_r;
  end

  // dividers for saturation and hue
  rhc_div #(
    .DEN_W (DW),
    .QUO_W (FW),
    .STEPS (STEPS_PER_STAGE)
  ) u_sat_div (
    .clk   (clk),
    .num_i (s2_sat_num_r),
    .den_i (s2_sat_den_r),
    .quo_o (sat_quo)
  );

  rhc_div #(
    .DEN_W (DW),
    .QUO_W (FW),
    .STEPS (STEPS_PER_STAGE)
  ) u_hue_div (
    .clk   (clk),
    .num_i (s2_hue_num_r),
    .den_i (s2_hue_den_r),
    .quo_o (hue_quo)
  );

  // lightness: fix the estimate by one compare, then add the integer part
  assign ten_s2 = TW'(s2_s_r) * TW'(rhc_pkg::LIGHT_FRAC_MUL);
  assign lrem   = ten_s2 - TW'(s2_lq_r) * TW'(rhc_pkg::LIGHT_DIVISOR);
  assign lq_fix = (lrem >= TW'(rhc_pkg::LIGHT_DIVISOR)) ? s2_lq_r + QW'(1) : s2_lq_r;

  always_comb begin
    sb0_nxt.grey  = s2_grey_r;
    sb0_nxt.light = FW'(s2_s_r) * FW'(rhc_pkg::LIGHT_SLOPE) + FW'(lq_fix);
  end

  // side line keeps pace with the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      dv_r[0] <= s2_v_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
    sb_r[0] <= sb0_nxt;
    for (int k = 1; k < DIV_STAGES; k++) begin
      sb_r[k] <= sb_r[k-1];
    end
  end

  // output stage: hue wrap and grey masking
  assign hue_wrap = (hue_quo >= FW'(rhc_pkg::HUE_FULL_TURN))
                    ? hue_quo - FW'(rhc_pkg::HUE_FULL_TURN) : hue_quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_r[DIV_STAGES-1];
    end
    out_data_r.hue_out        <= sb_r[DIV_STAGES-1].grey ? '0 : hue_wrap;
    out_data_r.saturation_out <= sb_r[DIV_STAGES-1].grey ? '0 : sat_quo;
    out_data_r.lightness_out  <= sb_r[DIV_STAGES-1].light;
    out_data_r.achromatic     <= sb_r[DIV_STAGES-1].grey;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // every accepted transfer produces a result strobe, and every strobe has a matching transfer
  a_latency_in : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("accepted pixel did not produce a result on time");

  a_latency_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transfer");

  a_grey_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.achromatic) |->
      (out_data.hue_out == '0 && out_data.saturation_out == '0))
    else $error("grey pixel with nonzero hue or saturation");

  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.hue_out < FW'(rhc_pkg::HUE_FULL_TURN)))
    else $error("hue not below a full turn");

  a_pct_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.saturation_out <= FW'(rhc_pkg::PCT_SCALE) &&
                    out_data.lightness_out <= FW'(rhc_pkg::PCT_SCALE)))
    else $error("saturation or lightness above full scale");

endmodule

// ===== bench/tb_rgb_to_hsl_convert_unit.sv =====
// self-checking testbench for the rgb to hsl converter
module tb_rgb_to_hsl_convert_unit;

  // run control
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 16;      // pipeline latency plus margin
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_GAP      = 40;

  // hsl arithmetic constants
  localparam int RED_WRAP_SECTORS = 6;
  localparam int GREEN_OFFSET     = 2;
  localparam int BLUE_OFFSET      = 4;

  // random pixel shapes
  typedef enum int {
    PIX_GREY,
    PIX_RED_GREEN_TIE,
    PIX_GREEN_BLUE_TIE,
    PIX_RED_BLUE_TIE,
    PIX_UNIFORM
  } pixel_shape_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  rhc_pkg::in_t in_data = '0;
  logic out_strobe;
  rhc_pkg::out_t out_data;

  rhc_pkg::out_t pending_hsl[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  rgb_to_hsl_convert_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // hue, saturation and lightness of one pixel, truncated fixed point
  function automatic rhc_pkg::out_t expected_hsl(input rhc_pkg::in_t px);
    rhc_pkg::out_t res;
    int r, g, b, hi, lo, span, total, den, num, hue;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    total = hi + lo;
    res = '0;
    res.lightness_out =
      rhc_pkg::FIELD_W'(total * rhc_pkg::PCT_SCALE / rhc_pkg::DOUBLE_FULL);
    res.achromatic = (span == 0);
    if (span != 0) begin
      den = (total > rhc_pkg::HALF_SUM) ? (rhc_pkg::DOUBLE_FULL - total) : total;
      if (den != 0) res.saturation_out = rhc_pkg::FIELD_W'(span * rhc_pkg::PCT_SCALE / den);
      // sector of the largest channel, red wins ties, then green
      if (hi == r) begin
        num = (g < b) ? (RED_WRAP_SECTORS * span + g - b) : (g - b);
      end else if (hi == g) begin
        num = b - r + GREEN_OFFSET * span;
      end else begin
        num = r - g + BLUE_OFFSET * span;
      end
      hue = num * rhc_pkg::HUE_SECTOR_SCALE / span;
      if (hue >= rhc_pkg::HUE_FULL_TURN) hue -= rhc_pkg::HUE_FULL_TURN;
      res.hue_out = rhc_pkg::FIELD_W'(hue);
    end
    return res;
  endfunction

  // one pixel transfer; start stays high for a following item
  task automatic send_pixel(input rhc_pkg::in_t px);
    start <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_hsl.push_back(expected_hsl(px));
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    rhc_pkg::in_t px;
    px.red_in = rhc_pkg::CH_W'(r);
    px.green_in = rhc_pkg::CH_W'(g);
    px.blue_in = rhc_pkg::CH_W'(b);
    send_pixel(px);
  endtask

  // random sender gap, geometric with the given percentage
  task automatic sender_gap(input int pct);
    int n;
    n = 0;
    while (n < MAX_GAP && $urandom_range(99) < pct) n++;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every expected result is back, then let the pipe settle
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic rhc_pkg::in_t random_pixel();
    rhc_pkg::in_t px;
    int v;
    pixel_shape_t shape;
    v = $urandom_range(9);
    shape = (v < PIX_UNIFORM) ? pixel_shape_t'(v) : PIX_UNIFORM;
    px.red_in = rhc_pkg::CH_W'($urandom);
    px.green_in = rhc_pkg::CH_W'($urandom);
    px.blue_in = rhc_pkg::CH_W'($urandom);
    case (shape)
      PIX_GREY: begin
        px.green_in = px.red_in;
        px.blue_in = px.red_in;
      end
      PIX_RED_GREEN_TIE: px.green_in = px.red_in;
      PIX_GREEN_BLUE_TIE: px.blue_in = px.green_in;
      PIX_RED_BLUE_TIE: px.blue_in = px.red_in;
      default: ;
    endcase
    return px;
  endfunction

  // corners of the color cube and single-step neighbors
  task automatic test_extremes();
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(1, 0, 0);
    send_rgb(0, 0, 1);
    send_rgb(254, 255, 255);
  endtask

  // equal channels give zero hue and saturation with the grey flag
  task automatic test_grey();
    send_rgb(128, 128, 128);
    send_rgb(127, 127, 127);
    send_rgb(1, 1, 1);
  endtask

  // sector choice, tie order, red wrap and the saturation fold point
  task automatic test_sectors();
    send_rgb(200, 10, 50);    // red largest, green below blue: wraps
    send_rgb(200, 50, 10);    // red largest, no wrap
    send_rgb(200, 30, 30);    // red largest, green equals blue
    send_rgb(180, 180, 20);   // red and green tie
    send_rgb(20, 180, 180);   // green and blue tie
    send_rgb(180, 20, 180);   // red and blue tie
    send_rgb(10, 200, 100);
    send_rgb(100, 10, 200);
    send_rgb(200, 55, 100);   // max + min exactly 255
    send_rgb(200, 56, 100);   // max + min just above 255
    wait_drained();
  endtask

  // random pixels with a given sender idle percentage
  task automatic test_random(input int count, input int idle_pct);
    repeat (count) begin
      send_pixel(random_pixel());
      sender_gap(idle_pct);
    end
    wait_drained();
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin
    rhc_pkg::out_t exp_hsl;
    if (rst_n && out_strobe) begin
      if (pending_hsl.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        mismatch_count++;
      end else begin
        exp_hsl = pending_hsl.pop_front();
        if (out_data.hue_out !== exp_hsl.hue_out) begin
          $display("%0t: hue expected %0d actual %0d", $time,
                   exp_hsl.hue_out, out_data.hue_out);
          mismatch_count++;
        end
        if (out_data.saturation_out !== exp_hsl.saturation_out) begin
          $display("%0t: saturation expected %0d actual %0d", $time,
                   exp_hsl.saturation_out, out_data.saturation_out);
          mismatch_count++;
        end
        if (out_data.lightness_out !== exp_hsl.lightness_out) begin
          $display("%0t: lightness expected %0d actual %0d", $time,
                   exp_hsl.lightness_out, out_data.lightness_out);
          mismatch_count++;
        end
        if (out_data.achromatic !== exp_hsl.achromatic) begin
          $display("%0t: achromatic expected %0d actual %0d", $time,
                   exp_hsl.achromatic, out_data.achromatic);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_grey();
    test_sectors();
    test_random(600, 0);
    test_random(400, 88);
    test_random(350, 0);
    test_random(400, 29);
    wait_drained();
    if (mismatch_count == 0 && pending_hsl.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
